[design/mips_subset_execute_unit_assert.svh]
// Assertion macros for the execute unit
`ifndef MIPS_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_ASSERT_SVH

// Clocked assertion with reset disable
`define MSE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds through reset
`define MSE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/mse_pkg.sv]
`default_nettype none
package mse_pkg;
    localparam int unsigned RegCount = 32;
    localparam int unsigned RegIdxW  = 5;
    localparam logic [31:0] ResetPcDefault = 32'hBFC0_0000;

    localparam logic [5:0] OpSpecial = 6'h00;
    localparam logic [5:0] OpJal     = 6'h03;
    localparam logic [5:0] OpBne     = 6'h05;
    localparam logic [5:0] OpBgtz    = 6'h07;
    localparam logic [5:0] OpAddiu   = 6'h09;
    localparam logic [5:0] OpOri     = 6'h0D;
    localparam logic [5:0] OpLui     = 6'h0F;
    localparam logic [5:0] OpCop0    = 6'h10;
    localparam logic [5:0] OpSpecial3 = 6'h1F;
    localparam logic [5:0] OpLw      = 6'h23;
    localparam logic [5:0] OpSw      = 6'h2B;
    localparam logic [5:0] OpCache   = 6'h2F;

    localparam logic [5:0] FnSll  = 6'h00;
    localparam logic [5:0] FnSllv = 6'h04;
    localparam logic [5:0] FnJr   = 6'h08;
    localparam logic [5:0] FnSync = 6'h0F;
    localparam logic [5:0] FnAddu = 6'h21;
    localparam logic [5:0] FnExt  = 6'h00;

    localparam logic [4:0] CopMf = 5'd0;
    localparam logic [4:0] CopMt = 5'd4;
    localparam logic [4:0] CopCt = 5'd6;

    localparam logic [1:0] MemNone  = 2'd0;
    localparam logic [1:0] MemRead  = 2'd1;
    localparam logic [1:0] MemWrite = 2'd2;

    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StUndefOp  = 3'd1;
    localparam logic [2:0] StUndefSp  = 3'd2;
    localparam logic [2:0] StUndefSp3 = 3'd3;
    localparam logic [2:0] StUndefCop = 3'd4;
    localparam logic [2:0] StOrder    = 3'd5;
    localparam logic [2:0] StHalted   = 3'd6;

    localparam logic [0:0] RegResetPc = 1'd0;

    typedef struct packed {
        logic        kind;
        logic [31:0] instr_word;
        logic [31:0] load_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] fetch_addr;
        logic [1:0]  mem_op;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic [2:0]  status;
    } t_out_item;
endpackage
`default_nettype wire

[design/mse_stream_if.sv]
`default_nettype none
interface mse_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/mips_subset_execute_unit.sv]
// MIPS32-style subset execute unit.
// i_in carries items: kind 0 is an instruction word fetched at the last
// fetch_addr given, kind 1 the data answering a pending LW read. Every
// accepted item yields exactly one result on o_out: the next fetch address,
// an optional word read or write request and a status code.
// The input is registered in stage 1 for the register file and CP0 memory
// reads; stage 2 executes, writes back and loads the output skid buffer.
// Throughput is one item per cycle while the skid buffer has room; a register
// written by one item is forwarded to the next, so no bubbles are inserted.
// A two-entry skid buffer sits on the output; when the receiver stalls the
// input stays ready until results in flight could overflow it.
// Reset (synchronous, active low) loads PC and reset_pc with ResetPcDefault and
// clears the control state. The register files are cleared by one valid bit per entry.
// An undefined encoding halts the unit until reset; later items give status
// halted. reset_pc sits at APB address 0; writing it restarts at that PC.
`default_nettype none
`include "mips_subset_execute_unit_assert.svh"
module mips_subset_execute_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mse_stream_if.sink  i_in,
    mse_stream_if.source o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mse_pkg::*;

    // ---------------- configuration
    logic [31:0] r_reset_pc;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegResetPc);
    assign prdata = (paddr[2] == RegResetPc) ? r_reset_pc : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_reset_pc <= ResetPcDefault;
        else if (cfg_wr) r_reset_pc <= pwdata;
    end

    // ---------------- stage 1: register read
    logic        in_fire;
    logic        r_v1;
    t_in_item    r_it1;
    logic [1:0]  r_cnt;           // results held in the skid buffer
    logic        out_fire;
    assign in_fire = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    // room for this item plus the one in stage 1
    assign i_in.ready = ({1'b0, r_cnt} + {2'b0, r_v1}) < 3'd2 || o_out.ready && r_cnt != 2'd0
                        && ({1'b0, r_cnt} + {2'b0, r_v1}) < 3'd3;

    logic [31:0] gpr_mem [RegCount];
    logic [31:0] cop_mem [RegCount];
    logic [RegCount-1:0] r_gpr_ok, r_cop_ok;
    logic [31:0] r_rd_s, r_rd_t, r_rd_c;
    logic [RegIdxW-1:0] ra_s, ra_t, ra_c;
    assign ra_s = i_in.payload.instr_word[25:21];
    assign ra_t = i_in.payload.instr_word[20:16];
    assign ra_c = i_in.payload.instr_word[15:11];

    logic                wb_gpr_en, wb_cop_en;
    logic [RegIdxW-1:0]  wb_gpr_a, wb_cop_a;
    logic [31:0]         wb_gpr_d, wb_cop_d;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_s <= gpr_mem[ra_s];
            r_rd_t <= gpr_mem[ra_t];
            r_rd_c <= cop_mem[ra_c];
            r_it1  <= i_in.payload;
        end
        if (wb_gpr_en) gpr_mem[wb_gpr_a] <= wb_gpr_d;
        if (wb_cop_en) cop_mem[wb_cop_a] <= wb_cop_d;
    end

    // valid flags and forwarding snapshot for stage 1
    logic        r_s_ok, r_t_ok, r_c_ok;
    logic        r_fw_s, r_fw_t, r_fw_c;
    logic [31:0] r_fw_d, r_fwc_d;
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s_ok <= r_gpr_ok[ra_s];
            r_t_ok <= r_gpr_ok[ra_t];
            r_c_ok <= r_cop_ok[ra_c];
            r_fw_s <= wb_gpr_en && wb_gpr_a == ra_s;
            r_fw_t <= wb_gpr_en && wb_gpr_a == ra_t;
            r_fw_c <= wb_cop_en && wb_cop_a == ra_c;
            r_fw_d <= wb_gpr_d;
            r_fwc_d <= wb_cop_d;
        end
    end

    // ---------------- stage 2: execute
    logic [31:0] r_pc, r_dtgt;
    logic        r_bp, r_lp, r_halted;
    logic [RegIdxW-1:0] r_ld;
    logic [RegIdxW-1:0] ex_rs, ex_rt, ex_rd, ex_sa;
    logic [31:0] iw, vs, vt, vc, slot, bofs, sum_si;
    logic [5:0]  op, fn;
    t_out_item   res;
    logic        take;
    logic [31:0] tgt;
    logic [2:0]  err;

    assign iw    = r_it1.instr_word;
    assign op    = iw[31:26];
    assign fn    = iw[5:0];
    assign ex_rs = iw[25:21];
    assign ex_rt = iw[20:16];
    assign ex_rd = iw[15:11];
    assign ex_sa = iw[10:6];

    always_comb begin
        vs = r_fw_s ? r_fw_d : (r_s_ok ? r_rd_s : 32'd0);
        vt = r_fw_t ? r_fw_d : (r_t_ok ? r_rd_t : 32'd0);
        vc = r_fw_c ? r_fwc_d : (r_c_ok ? r_rd_c : 32'd0);
        if (ex_rs == '0) vs = 32'd0;
        if (ex_rt == '0) vt = 32'd0;
    end

    assign slot   = r_pc + 32'd4;
    assign bofs   = {{14{iw[15]}}, iw[15:0], 2'b00};
    assign sum_si = vs + {{16{iw[15]}}, iw[15:0]};

    logic [31:0] ext_mask;
    assign ext_mask = 32'hFFFF_FFFF >> (5'd31 - ex_rd);

    always_comb begin
        res = '0;
        res.fetch_addr = r_pc;
        take = 1'b0;
        tgt = 32'd0;
        err = StOk;
        wb_gpr_en = 1'b0;
        wb_gpr_a = ex_rt;
        wb_gpr_d = 32'd0;
        wb_cop_en = 1'b0;
        wb_cop_a = ex_rd;
        wb_cop_d = vt;
        if (r_halted) begin
            res.status = StHalted;
        end else if (r_it1.kind) begin
            if (!r_lp) res.status = StOrder;
            else begin
                wb_gpr_en = 1'b1;
                wb_gpr_a = r_ld;
                wb_gpr_d = r_it1.load_data;
            end
        end else if (r_lp) begin
            res.status = StOrder;
        end else begin
            case (op)
                OpSpecial: begin
                    wb_gpr_a = ex_rd;
                    case (fn)
                        FnSll: begin wb_gpr_en = 1'b1; wb_gpr_d = vt << ex_sa; end
                        FnSllv: begin wb_gpr_en = 1'b1; wb_gpr_d = vt << vs[4:0]; end
                        FnJr: begin take = 1'b1; tgt = vs; end
                        FnSync: ;
                        FnAddu: begin wb_gpr_en = 1'b1; wb_gpr_d = vs + vt; end
                        default: err = StUndefSp;
                    endcase
                end
                OpJal: begin
                    take = 1'b1;
                    tgt = {slot[31:28], iw[25:0], 2'b00};
                    wb_gpr_en = 1'b1;
                    wb_gpr_a = 5'd31;
                    wb_gpr_d = slot + 32'd4;
                end
                OpBne: if (vs != vt) begin take = 1'b1; tgt = slot + bofs; end
                OpBgtz: if (vs != 32'd0 && !vs[31]) begin
                    take = 1'b1; tgt = slot + bofs;
                end
                OpAddiu: begin wb_gpr_en = 1'b1; wb_gpr_d = sum_si; end
                OpOri: begin wb_gpr_en = 1'b1; wb_gpr_d = vs | {16'd0, iw[15:0]}; end
                OpLui: begin wb_gpr_en = 1'b1; wb_gpr_d = {iw[15:0], 16'd0}; end
                OpCop0: begin
                    case (ex_rs)
                        CopMf: begin wb_gpr_en = 1'b1; wb_gpr_d = vc; end
                        CopMt: wb_cop_en = 1'b1;
                        CopCt: ;
                        default: err = StUndefCop;
                    endcase
                end
                OpSpecial3: begin
                    if (fn == FnExt) begin
                        wb_gpr_en = 1'b1;
                        wb_gpr_d = (vs >> ex_sa) & ext_mask;
                    end else err = StUndefSp3;
                end
                OpLw: begin res.mem_op = MemRead; res.mem_addr = sum_si; end
                OpSw: begin
                    res.mem_op = MemWrite; res.mem_addr = sum_si; res.mem_wdata = vt;
                end
                OpCache: ;
                default: err = StUndefOp;
            endcase
            if (err != StOk) begin
                res = '0;
                res.fetch_addr = r_pc;
                res.status = err;
                wb_gpr_en = 1'b0;
                wb_cop_en = 1'b0;
                take = 1'b0;
            end else begin
                res.fetch_addr = r_bp ? r_dtgt : slot;
            end
        end
        if (!r_v1) begin
            wb_gpr_en = 1'b0;
            wb_cop_en = 1'b0;
        end
        if (wb_gpr_a == '0) wb_gpr_en = 1'b0;
    end

    logic exec_ok;
    assign exec_ok = r_v1 && !r_halted && !r_it1.kind && !r_lp && err == StOk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_pc <= ResetPcDefault;
            r_dtgt <= 32'd0;
            r_bp <= 1'b0;
            r_lp <= 1'b0;
            r_ld <= '0;
            r_halted <= 1'b0;
            r_gpr_ok <= '0;
            r_cop_ok <= '0;
        end else begin
            r_v1 <= in_fire;
            if (wb_gpr_en) r_gpr_ok[wb_gpr_a] <= 1'b1;
            if (wb_cop_en) r_cop_ok[wb_cop_a] <= 1'b1;
            if (r_v1 && !r_halted) begin
                if (r_it1.kind && r_lp) r_lp <= 1'b0;
                if (exec_ok) begin
                    r_pc <= res.fetch_addr;
                    r_bp <= take;
                    if (take) r_dtgt <= tgt;
                    if (op == OpLw) begin
                        r_lp <= 1'b1;
                        r_ld <= ex_rt;
                    end
                end
                if (!r_it1.kind && !r_lp && err != StOk) r_halted <= 1'b1;
            end
            if (cfg_wr) begin
                r_pc <= pwdata;
                r_bp <= 1'b0;
            end
        end
    end

    // ---------------- output skid buffer (two entries)
    t_out_item r_q0, r_q1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= 2'd0;
        else r_cnt <= r_cnt + {1'b0, r_v1} - {1'b0, out_fire};
    end
    always_ff @(posedge i_clk) begin
        case ({r_v1, out_fire})
            2'b10: if (r_cnt == 2'd0) r_q0 <= res; else r_q1 <= res;
            2'b01: r_q0 <= r_q1;
            2'b11: if (r_cnt == 2'd1) r_q0 <= res; else begin r_q0 <= r_q1; r_q1 <= res; end
            default: ;
        endcase
    end
    assign o_out.valid = r_cnt != 2'd0;
    assign o_out.payload = r_q0;

    `MSE_ASSERT(a_no_overflow, i_clk, i_rst_n, !(r_cnt == 2'd2 && r_v1 && !out_fire), "skid overflow")
    `MSE_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "skid count out of range")
    `MSE_ASSERT(a_halt_sticky, i_clk, i_rst_n, $past(r_halted) && !$past(cfg_wr) |-> r_halted || !i_rst_n, "halt lost")
    `MSE_ASSERT(a_zero_reg, i_clk, i_rst_n, !(wb_gpr_en && wb_gpr_a == '0), "write to register zero")
endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
    import mse_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mse_stream_if #(.t_payload(t_in_item))  instr_ch ();
    mse_stream_if #(.t_payload(t_out_item)) result_ch ();

    mips_subset_execute_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(instr_ch.sink), .o_out(result_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Architectural state of the core as predicted
    logic [31:0] core_gpr [32];
    logic [31:0] core_cp0_status [32];
    logic [31:0] core_cp0_ctrl [32];
    logic [31:0] core_pc;
    logic [31:0] core_reset_pc;
    logic [31:0] core_target;
    logic        core_branch;
    logic        core_load;
    logic [4:0]  core_load_dest;
    logic [2:0]  core_halt;

    t_out_item   expected_results [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    bit          rx_stall_on = 1'b1;

    initial begin
        instr_ch.valid = 1'b0;
        instr_ch.payload = '0;
        result_ch.ready = 1'b0;
    end

    function automatic logic [31:0] sign_ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic void write_gpr(input logic [4:0] r, input logic [31:0] v);
        if (r != 5'd0) core_gpr[r] = v;
    endfunction

    function automatic void core_reset_state();
        for (int i = 0; i < 32; i++) begin
            core_gpr[i] = '0;
            core_cp0_status[i] = '0;
            core_cp0_ctrl[i] = '0;
        end
        core_reset_pc = ResetPcDefault;
        core_pc = ResetPcDefault;
        core_target = '0;
        core_branch = 1'b0;
        core_load = 1'b0;
        core_load_dest = '0;
        core_halt = StOk;
    endfunction

    function automatic t_out_item execute_item(input t_in_item it);
        t_out_item   r;
        logic [5:0]  op;
        logic [4:0]  rs, rt, rd, sa;
        logic [5:0]  fn;
        logic [31:0] vs, vt, slot, nxt, tgt;
        logic [2:0]  err;
        logic        take;
        r = '0;
        r.fetch_addr = core_pc;
        if (core_halt != StOk) begin
            r.status = StHalted;
            return r;
        end
        if (it.kind) begin
            if (!core_load) begin
                r.status = StOrder;
                return r;
            end
            write_gpr(core_load_dest, it.load_data);
            core_load = 1'b0;
            return r;
        end
        if (core_load) begin
            r.status = StOrder;
            return r;
        end
        op = it.instr_word[31:26];
        rs = it.instr_word[25:21];
        rt = it.instr_word[20:16];
        rd = it.instr_word[15:11];
        sa = it.instr_word[10:6];
        fn = it.instr_word[5:0];
        vs = core_gpr[rs];
        vt = core_gpr[rt];
        slot = core_pc + 32'd4;
        nxt = core_branch ? core_target : slot;
        tgt = '0;
        take = 1'b0;
        err = StOk;
        case (op)
            OpSpecial: begin
                case (fn)
                    FnSll:  write_gpr(rd, vt << sa);
                    FnSllv: write_gpr(rd, vt << vs[4:0]);
                    FnJr: begin
                        take = 1'b1;
                        tgt = vs;
                    end
                    FnSync: ;
                    FnAddu: write_gpr(rd, vs + vt);
                    default: err = StUndefSp;
                endcase
            end
            OpJal: begin
                take = 1'b1;
                tgt = {slot[31:28], it.instr_word[25:0], 2'b00};
                write_gpr(5'd31, slot + 32'd4);
            end
            OpBne: begin
                if (vs != vt) begin
                    take = 1'b1;
                    tgt = slot + (sign_ext16(it.instr_word[15:0]) << 2);
                end
            end
            OpBgtz: begin
                if (vs != 0 && !vs[31]) begin
                    take = 1'b1;
                    tgt = slot + (sign_ext16(it.instr_word[15:0]) << 2);
                end
            end
            OpAddiu: write_gpr(rt, vs + sign_ext16(it.instr_word[15:0]));
            OpOri:   write_gpr(rt, vs | {16'h0, it.instr_word[15:0]});
            OpLui:   write_gpr(rt, {it.instr_word[15:0], 16'h0});
            OpCop0: begin
                if (rs == CopMf) write_gpr(rt, core_cp0_status[rd]);
                else if (rs == CopMt) core_cp0_status[rd] = vt;
                else if (rs == CopCt) core_cp0_ctrl[rd] = vt;
                else err = StUndefCop;
            end
            OpSpecial3: begin
                if (fn == FnExt) write_gpr(rt, (vs >> sa) & (32'hFFFF_FFFF >> (5'd31 - rd)));
                else err = StUndefSp3;
            end
            OpLw: begin
                r.mem_op = MemRead;
                r.mem_addr = vs + sign_ext16(it.instr_word[15:0]);
                core_load = 1'b1;
                core_load_dest = rt;
            end
            OpSw: begin
                r.mem_op = MemWrite;
                r.mem_addr = vs + sign_ext16(it.instr_word[15:0]);
                r.mem_wdata = vt;
            end
            OpCache: ;
            default: err = StUndefOp;
        endcase
        if (err != StOk) begin
            core_halt = err;
            r = '0;
            r.fetch_addr = core_pc;
            r.status = err;
            return r;
        end
        core_pc = nxt;
        core_branch = take;
        if (take) core_target = tgt;
        r.fetch_addr = core_pc;
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: random stalls, compare each transfer with the oldest expectation
    always @(negedge i_clk) begin
        if (!rx_stall_on) result_ch.ready <= 1'b1;
        else result_ch.ready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            t_out_item got, want;
            got = result_ch.payload;
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: %p", $time, got);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                checked_count++;
                if (got.fetch_addr !== want.fetch_addr) begin
                    $display("%0t: fetch_addr exp %h got %h", $time, want.fetch_addr,
                             got.fetch_addr);
                    fail_count++;
                end
                if (got.mem_op !== want.mem_op) begin
                    $display("%0t: mem_op exp %0d got %0d", $time, want.mem_op, got.mem_op);
                    fail_count++;
                end
                if (got.mem_addr !== want.mem_addr) begin
                    $display("%0t: mem_addr exp %h got %h", $time, want.mem_addr,
                             got.mem_addr);
                    fail_count++;
                end
                if (got.mem_wdata !== want.mem_wdata) begin
                    $display("%0t: mem_wdata exp %h got %h", $time, want.mem_wdata,
                             got.mem_wdata);
                    fail_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Hold valid across back-to-back items; drop it only for a gap
    task automatic send_item(input t_in_item it);
        int g;
        g = gap_len();
        if (g != 0) begin
            instr_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        instr_ch.payload <= it;
        instr_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!instr_ch.ready);
        expected_results.push_back(execute_item(it));
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic send_instr(input logic [31:0] w);
        t_in_item it;
        it.kind = 1'b0;
        it.instr_word = w;
        it.load_data = $urandom();
        send_item(it);
    endtask

    task automatic send_load_data(input logic [31:0] d);
        t_in_item it;
        it.kind = 1'b1;
        it.instr_word = $urandom();
        it.load_data = d;
        send_item(it);
    endtask

    task automatic drain_results();
        instr_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_write_reset_pc(input logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {RegResetPc, 2'b00};
        pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        core_reset_pc = v;
        core_pc = v;
        core_branch = 1'b0;
    endtask

    function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] rtype(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [4:0] sa, input logic [5:0] fn);
        return {op, rs, rt, rd, sa, fn};
    endfunction

    // A random instruction from the valid subset; undefined ones only when asked
    function automatic logic [31:0] rand_instr(input bit allow_undef);
        logic [4:0] rs, rt, rd, sa;
        logic [15:0] imm;
        int sel;
        rs = 5'($urandom_range(0, 7));
        rt = 5'($urandom_range(0, 7));
        rd = 5'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0) begin
            rs = 5'($urandom());
            rt = 5'($urandom());
            rd = 5'($urandom());
        end
        sa = 5'($urandom());
        imm = 16'($urandom());
        sel = $urandom_range(0, allow_undef ? 18 : 17);
        case (sel)
            0: return itype(OpAddiu, rs, rt, imm);
            1: return rtype(OpSpecial, rs, rt, rd, sa, FnAddu);
            2: return itype(OpOri, rs, rt, imm);
            3: return itype(OpLui, rs, rt, imm);
            4: return rtype(OpSpecial, rs, rt, rd, sa, FnSll);
            5: return rtype(OpSpecial, rs, rt, rd, sa, FnSllv);
            6: return rtype(OpSpecial3, rs, rt, rd, sa, FnExt);
            7: return itype(OpBne, rs, rt, imm);
            8: return itype(OpBgtz, rs, rt, imm);
            9: return {OpJal, 26'($urandom())};
            10: return rtype(OpSpecial, rs, rt, rd, sa, FnJr);
            11: return itype(OpLw, rs, rt, imm);
            12: return itype(OpSw, rs, rt, imm);
            13: return rtype(OpCop0, CopMf, rt, rd, sa, 6'($urandom()));
            14: return rtype(OpCop0, CopMt, rt, rd, sa, 6'($urandom()));
            15: return rtype(OpCop0, CopCt, rt, rd, sa, 6'($urandom()));
            16: return itype(OpCache, rs, rt, imm);
            17: return rtype(OpSpecial, rs, rt, rd, sa, FnSync);
            default: return $urandom();
        endcase
    endfunction

    // Random instruction stream with loads answered in order
    task automatic run_random(input int count, input bit allow_undef);
        logic [31:0] w;
        for (int i = 0; i < count && core_halt == StOk; i++) begin
            if (core_load && $urandom_range(0, 19) != 0) begin
                send_load_data($urandom());
            end else if (!core_load && $urandom_range(0, 39) == 0) begin
                send_load_data($urandom());
            end else begin
                w = rand_instr(allow_undef);
                send_instr(w);
            end
        end
    endtask

    task automatic test_directed_ops();
        send_instr(itype(OpLui, 5'd0, 5'd1, 16'hFFFF));
        send_instr(itype(OpOri, 5'd1, 5'd1, 16'hFFFF));
        send_instr(itype(OpAddiu, 5'd0, 5'd2, 16'h7FFF));
        send_instr(itype(OpAddiu, 5'd1, 5'd3, 16'h8000));
        send_instr(rtype(OpSpecial, 5'd1, 5'd2, 5'd4, 5'd0, FnAddu));
        send_instr(rtype(OpSpecial, 5'd0, 5'd1, 5'd5, 5'd31, FnSll));
        send_instr(rtype(OpSpecial, 5'd2, 5'd1, 5'd6, 5'd0, FnSllv));
        // field overrun: pos 20, size 32
        send_instr(rtype(OpSpecial3, 5'd1, 5'd7, 5'd31, 5'd20, FnExt));
        send_instr(rtype(OpSpecial3, 5'd1, 5'd8, 5'd0, 5'd0, FnExt));
        send_instr(itype(OpSw, 5'd1, 5'd1, 16'h8000));
        send_instr(itype(OpLw, 5'd2, 5'd0, 16'h7FFF));
        send_instr(itype(OpAddiu, 5'd0, 5'd9, 16'h1));   // out of order while loading
        send_load_data(32'hFFFF_FFFF);                    // destination zero, discarded
        send_load_data(32'h0);                            // nothing pending
        send_instr(itype(OpLw, 5'd0, 5'd10, 16'h0));
        send_load_data(32'hA5A5_5A5A);
        send_instr(rtype(OpCop0, CopMt, 5'd1, 5'd31, 5'd0, 6'd0));
        send_instr(rtype(OpCop0, CopCt, 5'd10, 5'd3, 5'd0, 6'd0));
        send_instr(rtype(OpCop0, CopMf, 5'd11, 5'd31, 5'd0, 6'd0));
        send_instr(itype(OpCache, 5'd0, 5'd0, 16'h0));
        send_instr(rtype(OpSpecial, 5'd0, 5'd0, 5'd0, 5'd0, FnSync));
        // branch in the delay slot of a branch, then JAL and JR
        send_instr(itype(OpBne, 5'd1, 5'd0, 16'h0010));
        send_instr(itype(OpBgtz, 5'd2, 5'd0, 16'hFFF0));
        send_instr({OpJal, 26'h3FF_FFFF});
        send_instr(rtype(OpSpecial, 5'd31, 5'd0, 5'd0, 5'd0, FnJr));
        send_instr(itype(OpAddiu, 5'd0, 5'd0, 16'h0));
    endtask

    task automatic test_undefined(input logic [31:0] w);
        send_instr(w);
        send_instr(rand_instr(1'b0));
        send_load_data($urandom());
    endtask

    task automatic test_random_phase(input logic [31:0] pc, input int count,
                                     input bit allow_undef);
        apb_write_reset_pc(pc);
        run_random(count, allow_undef);
        drain_results();
    endtask

    initial begin
        core_reset_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        drain_results();
        test_random_phase(32'h0000_0000, 200, 1'b0);
        // receiver never stalls here
        rx_stall_on = 1'b0;
        test_random_phase(32'hFFFF_FFFC, 200, 1'b0);
        rx_stall_on = 1'b1;
        test_random_phase($urandom(), 250, 1'b0);
        test_random_phase(32'h8000_0000, 250, 1'b0);
        run_random(100, 1'b1);
        // undefined encodings halt the core until reset, so they come last
        test_undefined(rtype(OpCop0, 5'd1, 5'd0, 5'd0, 5'd0, 6'd0));
        test_undefined(rtype(OpSpecial, 5'd0, 5'd0, 5'd0, 5'd0, 6'h3F));
        drain_results();
        $display("Sent %0d items and checked %0d results over five reset_pc settings,",
                 sent_count, checked_count);
        $display("covering every opcode, delay-slot branches, loads and halts.");
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
